/* hw/rtl/ofs_pkg.sv */
`timescale 1ns / 1ps
package ofs_pkg;
    localparam int unsigned DEF_WIDTH = 16;
    localparam int unsigned STATUS_W  = 3;

    localparam logic [STATUS_W-1:0] ST_GCD_HIT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SPLIT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ODD     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRIVIAL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;
endpackage

/* hw/rtl/order_finding_factor_split_core.sv */
`timescale 1ns / 1ps
// Channel  | Direction | tdata fields (low bit up)
// s_       | in        | modulus, base_value
// m_       | out       | factor_one, factor_two, order_found, status
//
// One request at a time: s_tready is high only while idle.
// Every reduction, gcd remainder and modular multiply runs through one shared restoring divider.
// A request makes k divider calls, k = gcd steps plus order-search and power multiplies,
// up to about 1.5*N+4*WIDTH.
// aresetn clears control state synchronously; a held result waits for m_tready.
module order_finding_factor_split_core #(
    parameter int unsigned WIDTH = ofs_pkg::DEF_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // modulus, base_value
    input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // factor_one, factor_two, order_found, status
    output logic [((3 * WIDTH + ofs_pkg::STATUS_W + 7) / 8) * 8 - 1:0] m_tdata
);
    localparam int unsigned RAW_W  = 3 * WIDTH + ofs_pkg::STATUS_W;
    localparam int unsigned DOUT_W = ((RAW_W + 7) / 8) * 8;
    localparam int unsigned DW     = 2 * WIDTH;
    localparam int unsigned CW     = $clog2(DW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_RED, S_GCD, S_GUPD, S_GDONE, S_COF,
        S_ORD, S_ORDM, S_POW, S_POWM, S_OUT
    } state_t;

    typedef enum logic [1:0] { G_A, G_P1, G_P2 } gsel_t;

    state_t                   state_reg, ret_reg;
    gsel_t                    gsel_reg;
    logic [DW-1:0]            num_reg;
    logic [WIDTH-1:0]         rem_reg, den_reg;
    logic [CW-1:0]            cnt_reg;
    logic [WIDTH-1:0]         n_reg, a_reg, gx_reg, gy_reg, cur_reg, x_reg, p1_reg;
    logic [WIDTH:0]           r_reg;
    logic [WIDTH-1:0]         pcnt_reg;
    logic [WIDTH-1:0]         f1_reg, f2_reg, ord_reg;
    logic [ofs_pkg::STATUS_W-1:0] st_reg;

    logic [WIDTH:0]           trial;
    logic                     qbit;
    logic [WIDTH-1:0]         base_in, n_in;

    assign n_in    = s_tdata[WIDTH-1:0];
    assign base_in = s_tdata[2*WIDTH-1:WIDTH];
    assign trial   = {rem_reg, num_reg[DW-1]};
    assign qbit    = (trial >= {1'b0, den_reg});

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {{(DOUT_W-RAW_W){1'b0}}, st_reg, ord_reg, f2_reg, f1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        n_reg <= n_in;
                        if (n_in < WIDTH'(2)) begin
                            f1_reg    <= '0;
                            f2_reg    <= '0;
                            ord_reg   <= '0;
                            st_reg    <= ofs_pkg::ST_BAD;
                            state_reg <= S_OUT;
                        end else begin
                            num_reg   <= DW'(base_in);
                            den_reg   <= n_in;
                            rem_reg   <= '0;
                            cnt_reg   <= CW'(DW);
                            ret_reg   <= S_RED;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // shift in one dividend bit, subtract when it fits
                    rem_reg <= qbit ? WIDTH'(trial - {1'b0, den_reg}) : trial[WIDTH-1:0];
                    num_reg <= {num_reg[DW-2:0], qbit};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) state_reg <= ret_reg;
                end
                S_RED: begin
                    a_reg     <= rem_reg;
                    gx_reg    <= rem_reg;
                    gy_reg    <= n_reg;
                    gsel_reg  <= G_A;
                    state_reg <= S_GCD;
                end
                S_GCD: begin
                    if (gy_reg == '0) begin
                        state_reg <= S_GDONE;
                    end else begin
                        num_reg   <= DW'(gx_reg);
                        den_reg   <= gy_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(DW);
                        ret_reg   <= S_GUPD;
                        state_reg <= S_DIV;
                    end
                end
                S_GUPD: begin
                    gx_reg    <= gy_reg;
                    gy_reg    <= rem_reg;
                    state_reg <= S_GCD;
                end
                S_GDONE: begin
                    unique case (gsel_reg)
                        G_A: begin
                            if (gx_reg != WIDTH'(1)) begin
                                f1_reg    <= gx_reg;
                                num_reg   <= DW'(n_reg);
                                den_reg   <= gx_reg;
                                rem_reg   <= '0;
                                cnt_reg   <= CW'(DW);
                                ret_reg   <= S_COF;
                                state_reg <= S_DIV;
                            end else begin
                                cur_reg   <= a_reg;
                                r_reg     <= (WIDTH+1)'(1);
                                state_reg <= S_ORD;
                            end
                        end
                        G_P1: begin
                            p1_reg   <= gx_reg;
                            gx_reg   <= n_reg;
                            gy_reg   <= ((WIDTH+1)'(x_reg) + (WIDTH+1)'(1) == {1'b0, n_reg})
                                        ? '0 : x_reg + WIDTH'(1);
                            gsel_reg <= G_P2;
                            state_reg <= S_GCD;
                        end
                        G_P2: begin
                            ord_reg <= r_reg[WIDTH-1:0];
                            if (p1_reg == WIDTH'(1) || gx_reg == WIDTH'(1)) begin
                                f1_reg <= '0;
                                f2_reg <= '0;
                                st_reg <= ofs_pkg::ST_TRIVIAL;
                            end else begin
                                f1_reg <= p1_reg;
                                f2_reg <= gx_reg;
                                st_reg <= ofs_pkg::ST_SPLIT;
                            end
                            state_reg <= S_OUT;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_COF: begin
                    f2_reg    <= num_reg[WIDTH-1:0];
                    ord_reg   <= '0;
                    st_reg    <= ofs_pkg::ST_GCD_HIT;
                    state_reg <= S_OUT;
                end
                S_ORD: begin
                    if (cur_reg != WIDTH'(1) && !r_reg[WIDTH]) begin
                        num_reg   <= DW'(cur_reg) * DW'(a_reg);
                        den_reg   <= n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(DW);
                        ret_reg   <= S_ORDM;
                        state_reg <= S_DIV;
                    end else if (r_reg[0]) begin
                        f1_reg    <= '0;
                        f2_reg    <= '0;
                        ord_reg   <= r_reg[WIDTH-1:0];
                        st_reg    <= ofs_pkg::ST_ODD;
                        state_reg <= S_OUT;
                    end else begin
                        x_reg     <= WIDTH'(1);
                        pcnt_reg  <= r_reg[WIDTH:1];
                        state_reg <= S_POW;
                    end
                end
                S_ORDM: begin
                    cur_reg   <= rem_reg;
                    r_reg     <= r_reg + (WIDTH+1)'(1);
                    state_reg <= S_ORD;
                end
                S_POW: begin
                    if (pcnt_reg != '0) begin
                        num_reg   <= DW'(x_reg) * DW'(a_reg);
                        den_reg   <= n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(DW);
                        ret_reg   <= S_POWM;
                        state_reg <= S_DIV;
                    end else begin
                        gx_reg    <= n_reg;
                        gy_reg    <= (x_reg == '0) ? n_reg - WIDTH'(1) : x_reg - WIDTH'(1);
                        gsel_reg  <= G_P1;
                        state_reg <= S_GCD;
                    end
                end
                S_POWM: begin
                    x_reg     <= rem_reg;
                    pcnt_reg  <= pcnt_reg - WIDTH'(1);
                    state_reg <= S_POW;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready and valid together");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st_reg <= ofs_pkg::ST_BAD) else $error("status out of range");
    a_retry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st_reg == ofs_pkg::ST_ODD || st_reg == ofs_pkg::ST_TRIVIAL
        || st_reg == ofs_pkg::ST_BAD) |-> f1_reg == '0 && f2_reg == '0)
        else $error("factors on retry");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg != '0) else $error("divide by zero");
`endif
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    localparam int unsigned W = 16;
    localparam int unsigned LIMIT_CYCLES = 40_000_000;

    typedef struct packed {
        logic [2:0]   status;
        logic [W-1:0] order_found;
        logic [W-1:0] factor_two;
        logic [W-1:0] factor_one;
    } split_result_t;

    class split_board;
        split_result_t pending[$];
        int            errors = 0;

        static function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        static function longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                                   longint unsigned m);
            longint unsigned acc;
            acc = 1 % m;
            b = b % m;
            while (e != 0) begin
                if (e[0]) acc = (acc * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return acc;
        endfunction

        static function split_result_t factor_split(logic [W-1:0] n_in, logic [W-1:0] b_in);
            split_result_t   res;
            longint unsigned n, a, g, cur, r, x, p1, p2;
            res = '0;
            n = n_in;
            if (n < 2) begin
                res.status = ofs_pkg::ST_BAD;
                return res;
            end
            a = b_in % n;
            g = gcd_of(a, n);
            if (g != 1) begin
                res.factor_one = g[W-1:0];
                res.factor_two = W'(n / g);
                res.status     = ofs_pkg::ST_GCD_HIT;
                return res;
            end
            cur = a;
            r   = 1;
            while (cur != 1 && r < (64'd1 << W)) begin
                cur = (cur * a) % n;
                r++;
            end
            res.order_found = r[W-1:0];
            if (r[0]) begin
                res.status = ofs_pkg::ST_ODD;
            end else begin
                x  = power_mod(a, r >> 1, n);
                p1 = gcd_of(n, (x + n - 1) % n);
                p2 = gcd_of(n, (x + 1) % n);
                if (p1 == 1 || p2 == 1) begin
                    res.status = ofs_pkg::ST_TRIVIAL;
                end else begin
                    res.factor_one = p1[W-1:0];
                    res.factor_two = p2[W-1:0];
                    res.status     = ofs_pkg::ST_SPLIT;
                end
            end
            return res;
        endfunction

        function void note_request(logic [W-1:0] n, logic [W-1:0] b);
            pending.push_back(factor_split(n, b));
        endfunction

        function void check_result(split_result_t got);
            split_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.factor_one !== want.factor_one) begin
                $display("%0t: factor_one exp %0d got %0d", $time, want.factor_one,
                         got.factor_one);
                errors++;
            end
            if (got.factor_two !== want.factor_two) begin
                $display("%0t: factor_two exp %0d got %0d", $time, want.factor_two,
                         got.factor_two);
                errors++;
            end
            if (got.order_found !== want.order_found) begin
                $display("%0t: order_found exp %0d got %0d", $time, want.order_found,
                         got.order_found);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    split_board  board = new();
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    longint      cycles = 0;

    order_finding_factor_split_core #(.WIDTH(W)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // check results, then drive tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(split_result_t'(m_tdata[50:0]));
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    task automatic send_request(logic [W-1:0] n, logic [W-1:0] b);
        while (!no_idle && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, n};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(n, b);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    logic [W-1:0] n_r, b_r;
    int           pick;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes and each status class
        send_request(16'd0, 16'd0);
        send_request(16'd1, 16'hFFFF);
        send_request(16'd2, 16'd0);
        send_request(16'd2, 16'd1);
        send_request(16'hFFFF, 16'd2);      // order 16
        send_request(16'hFFFF, 16'hFFFF);   // base reduces to zero
        send_request(16'hFFFE, 16'hFFFF);   // base reduces to one
        send_request(16'd15, 16'd2);        // split 3 and 5
        send_request(16'd21, 16'd2);        // split
        send_request(16'd15, 16'd14);       // x = N-1, gcd gives N
        send_request(16'd7, 16'd2);         // odd order
        send_request(16'd7, 16'd3);         // trivial
        send_request(16'd35, 16'd14);       // gcd hit
        send_request(16'd9, 16'd27);        // base multiple of modulus
        send_request(16'd8, 16'd3);
        send_request(16'd33, 16'hFFFF);
        hold_req = 1'b1;                    // long receiver stall; next request waits
        send_request(16'd55, 16'd2);
        send_request(16'd3, 16'd2);
        drain_results();

        for (int i = 0; i < 100; i++) begin
            no_idle = (i >= 40 && i < 60);
            pick = $urandom_range(99);
            b_r  = 16'($urandom);
            if (pick < 8) begin
                n_r = 16'($urandom_range(1));
            end else if (pick < 18) begin
                // large even modulus and even base: cheap gcd hit
                n_r = 16'($urandom) | 16'h8000;
                n_r[0] = 1'b0;
                b_r[0] = 1'b0;
            end else begin
                n_r = 16'($urandom_range(2, 63));
            end
            send_request(n_r, b_r);
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
